// ----- sv/mss_pkg.sv -----
// shared types, microcode table and segment table of the seven-segment scanner
package mss_pkg;

  localparam int DIGITS = 2;
  localparam int DIG_W  = $clog2(DIGITS);
  localparam int NUM_W  = $clog2(DIGITS + 1);

  localparam logic [7:0]  BLANK_CODE = 8'd10;
  localparam logic [31:0] RECIP10    = 32'hCCCCCCCD;

  typedef logic [DIG_W-1:0] digit_t;
  typedef logic [NUM_W-1:0] count_t;
  typedef logic [7:0]       code_t;
  typedef logic [3:0]       step_t;

  typedef enum logic [2:0] {
    CMD_TICK       = 3'd0,
    CMD_SET_CHAR   = 3'd1,
    CMD_SET_POINT  = 3'd2,
    CMD_SET_FLASH  = 3'd3,
    CMD_SET_NUMBER = 3'd4,
    CMD_CLEAR      = 3'd5
  } cmd_t;

  typedef enum logic [3:0] {
    OP_NOP       = 4'd0,
    OP_TICK_CNT  = 4'd1,
    OP_TICK_EMIT = 4'd2,
    OP_SET_CHAR  = 4'd3,
    OP_SET_POINT = 4'd4,
    OP_SET_FLASH = 4'd5,
    OP_NUM_DIV   = 4'd6,
    OP_NUM_WRITE = 4'd7,
    OP_CLEAR     = 4'd8
  } op_t;

  typedef enum logic [2:0] {
    COND_DISPATCH = 3'd0,
    COND_NEXT     = 3'd1,
    COND_JUMP     = 3'd2,
    COND_WAIT_OUT = 3'd3,
    COND_IF_DONE  = 3'd4
  } cond_t;

  localparam step_t S_IDLE   = 4'd0;
  localparam step_t S_TICK1  = 4'd1;
  localparam step_t S_TICK2  = 4'd2;
  localparam step_t S_SETC   = 4'd3;
  localparam step_t S_SETP   = 4'd4;
  localparam step_t S_SETF   = 4'd5;
  localparam step_t S_NUMCHK = 4'd6;
  localparam step_t S_NUMDIV = 4'd7;
  localparam step_t S_NUMWR  = 4'd8;
  localparam step_t S_CLR    = 4'd9;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t target;
  } ucode_t;

  typedef struct packed {
    logic accept;
    op_t  op;
  } ctrl_t;

  typedef struct packed {
    logic out_busy;
    logic num_done;
  } stat_t;

  function automatic ucode_t ucode_rom(input step_t s);
    ucode_t w;
    case (s)
      S_IDLE:   w = '{OP_NOP,       COND_DISPATCH, S_IDLE};
      S_TICK1:  w = '{OP_TICK_CNT,  COND_NEXT,     S_IDLE};
      S_TICK2:  w = '{OP_TICK_EMIT, COND_WAIT_OUT, S_IDLE};
      S_SETC:   w = '{OP_SET_CHAR,  COND_JUMP,     S_IDLE};
      S_SETP:   w = '{OP_SET_POINT, COND_JUMP,     S_IDLE};
      S_SETF:   w = '{OP_SET_FLASH, COND_JUMP,     S_IDLE};
      S_NUMCHK: w = '{OP_NOP,       COND_IF_DONE,  S_IDLE};
      S_NUMDIV: w = '{OP_NUM_DIV,   COND_NEXT,     S_IDLE};
      S_NUMWR:  w = '{OP_NUM_WRITE, COND_JUMP,     S_NUMCHK};
      S_CLR:    w = '{OP_CLEAR,     COND_JUMP,     S_IDLE};
      default:  w = '{OP_NOP,       COND_JUMP,     S_IDLE};
    endcase
    return w;
  endfunction

  function automatic step_t entry_of(input logic [2:0] cmd);
    step_t s;
    case (cmd)
      CMD_TICK:       s = S_TICK1;
      CMD_SET_CHAR:   s = S_SETC;
      CMD_SET_POINT:  s = S_SETP;
      CMD_SET_FLASH:  s = S_SETF;
      CMD_SET_NUMBER: s = S_NUMCHK;
      CMD_CLEAR:      s = S_CLR;
      default:        s = S_IDLE;
    endcase
    return s;
  endfunction

  function automatic logic [6:0] seg_pattern(input code_t c);
    logic [6:0] p;
    case (c)
      8'd0:    p = 7'h3F;
      8'd1:    p = 7'h06;
      8'd2:    p = 7'h5B;
      8'd3:    p = 7'h4F;
      8'd4:    p = 7'h66;
      8'd5:    p = 7'h6D;
      8'd6:    p = 7'h7D;
      8'd7:    p = 7'h07;
      8'd8:    p = 7'h7F;
      8'd9:    p = 7'h6F;
      8'd11:   p = 7'h79;
      8'd12:   p = 7'h73;
      default: p = 7'h00;
    endcase
    return p;
  endfunction

endpackage

// ----- sv/multiplexed_seven_segment_scanner.sv -----
// top level of the multiplexed seven-segment scanner
// tick: count step, then emit step registering the result, which waits while the output stalls
// set char, set point, set flash, clear: a write step, then back to dispatch
// set number: a done check, then one division step and one write per digit
// one request at a time, order kept by the microcode step counter
// reset: codes, flags, counter and scan cleared, half period 100, no clearing pass
module multiplexed_seven_segment_scanner (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // position, code, flag, option, number, length
  input  logic [2:0]  in_tuser,   // cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // segments
  output logic        out_tuser,  // digit_index
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);
  import mss_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  mss_useq u_useq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tuser  (in_tuser),
    .in_tready (in_tready),
    .stat      (stat),
    .ctrl      (ctrl)
  );

  mss_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (ctrl),
    .in_tdata   (in_tdata),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata),
    .stat       (stat)
  );

endmodule

// ----- sv/mss_useq.sv -----
// microcode sequencer: step counter, control rom and conditional jumps
module mss_useq (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  input  logic [2:0]    in_tuser,
  output logic          in_tready,
  input  mss_pkg::stat_t stat,
  output mss_pkg::ctrl_t ctrl
);
  import mss_pkg::*;

  step_t  step_r;
  step_t  step_nxt;
  ucode_t uw;
  logic   accept;

  assign uw        = ucode_rom(step_r);
  assign in_tready = (uw.cond == COND_DISPATCH);
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    case (uw.cond)
      COND_DISPATCH: step_nxt = accept ? entry_of(in_tuser) : S_IDLE;
      COND_NEXT:     step_nxt = step_r + 4'd1;
      COND_JUMP:     step_nxt = uw.target;
      COND_WAIT_OUT: step_nxt = stat.out_busy ? step_r : uw.target;
      COND_IF_DONE:  step_nxt = stat.num_done ? uw.target : step_r + 4'd1;
      default:       step_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= S_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

  assign ctrl.accept = accept;
  assign ctrl.op     = uw.op;

endmodule

// ----- sv/mss_datapath.sv -----
// display datapath: digit store, blink counter, decimal conversion and output register
module mss_datapath (
  input  logic           clk,
  input  logic           rst_n,
  input  mss_pkg::ctrl_t ctrl,
  input  logic [47:0]    in_tdata,
  input  logic           cfg_we,
  input  logic [15:0]    cfg_wdata,
  input  logic           out_tready,
  output logic           out_tvalid,
  output logic           out_tuser,
  output logic [7:0]     out_tdata,
  output mss_pkg::stat_t stat
);
  import mss_pkg::*;

  logic [15:0] half_r;
  code_t       codes_r   [DIGITS];
  logic        point_r   [DIGITS];
  logic        cblink_r  [DIGITS];
  logic        pblink_r  [DIGITS];
  logic [16:0] cnt_r;
  logic [16:0] cnt_nxt;
  digit_t      scan_r;
  digit_t      scan_nxt;

  digit_t      pos_r;
  code_t       code_r;
  logic        flag_r;
  logic        opt_r;
  logic [31:0] rest_r;
  logic [31:0] q_r;
  count_t      len_r;
  count_t      i_r;

  logic        out_tvalid_r;
  logic        out_tuser_r;
  logic [7:0]  out_tdata_r;

  logic [16:0] cnt_inc;
  logic [16:0] twice;
  logic        visible;
  code_t       shown_code;
  logic        shown_point;
  logic        emit;
  logic        out_busy;
  logic [63:0] prod;
  logic [31:0] q10;
  logic [31:0] diff;
  logic [3:0]  dec_digit;
  logic        lead_blank;
  count_t      len_in;
  logic [1:0]  length_in;

  // request payload fields
  assign length_in = in_tdata[44:43];
  assign len_in    = (int'(length_in) > DIGITS) ? NUM_W'(DIGITS) : NUM_W'(length_in);

  // blink counter and scan advance
  assign cnt_inc  = cnt_r + 17'd1;
  assign twice    = {half_r, 1'b0};
  assign cnt_nxt  = (cnt_inc > twice) ? (cnt_inc - twice) : cnt_inc;
  assign scan_nxt = (int'(scan_r) == DIGITS - 1) ? '0 : scan_r + 1'b1;

  assign visible     = cnt_r < {1'b0, half_r};
  assign shown_code  = (cblink_r[scan_r] && !visible) ? BLANK_CODE : codes_r[scan_r];
  assign shown_point = point_r[scan_r] && !(pblink_r[scan_r] && !visible);

  assign out_busy = out_tvalid_r && !out_tready;
  assign emit     = (ctrl.op == OP_TICK_EMIT) && !out_busy;

  // divide by ten through the reciprocal, remainder in the next step
  assign prod       = rest_r * RECIP10;
  assign q10        = {q_r[28:0], 3'b000} + {q_r[30:0], 1'b0};
  assign diff       = rest_r - q10;
  assign dec_digit  = diff[3:0];
  assign lead_blank = (i_r != '0) && opt_r && (dec_digit == 4'd0) && (q_r == 32'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_r       <= 16'd100;
      cnt_r        <= '0;
      scan_r       <= '0;
      out_tvalid_r <= 1'b0;
      i_r          <= '0;
      for (int k = 0; k < DIGITS; k++) begin
        codes_r[k]  <= '0;
        point_r[k]  <= 1'b0;
        cblink_r[k] <= 1'b0;
        pblink_r[k] <= 1'b0;
      end
    end else begin
      if (cfg_we) begin
        half_r <= cfg_wdata;
      end
      if (emit) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      if (ctrl.accept) begin
        i_r <= '0;
      end
      case (ctrl.op)
        OP_TICK_CNT: begin
          cnt_r  <= cnt_nxt;
          scan_r <= scan_nxt;
        end
        OP_SET_CHAR: begin
          if (int'(pos_r) < DIGITS) codes_r[pos_r] <= code_r;
        end
        OP_SET_POINT: begin
          if (int'(pos_r) < DIGITS) point_r[pos_r] <= flag_r;
        end
        OP_SET_FLASH: begin
          if (int'(pos_r) < DIGITS) begin
            if (opt_r) pblink_r[pos_r] <= flag_r;
            else       cblink_r[pos_r] <= flag_r;
          end
        end
        OP_NUM_WRITE: begin
          codes_r[i_r[DIG_W-1:0]] <= lead_blank ? BLANK_CODE : {4'd0, dec_digit};
          i_r <= i_r + 1'b1;
        end
        OP_CLEAR: begin
          for (int k = 0; k < DIGITS; k++) begin
            codes_r[k]  <= BLANK_CODE;
            point_r[k]  <= 1'b0;
            cblink_r[k] <= 1'b0;
            pblink_r[k] <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.accept) begin
      pos_r  <= in_tdata[DIG_W-1:0];
      code_r <= in_tdata[8:1];
      flag_r <= in_tdata[9];
      opt_r  <= in_tdata[10];
      rest_r <= in_tdata[42:11];
      len_r  <= len_in;
    end else if (ctrl.op == OP_NUM_WRITE) begin
      rest_r <= q_r;
    end
    if (ctrl.op == OP_NUM_DIV) begin
      q_r <= {3'b000, prod[63:35]};
    end
    if (emit) begin
      out_tuser_r <= scan_r;
      out_tdata_r <= {shown_point, seg_pattern(shown_code)};
    end
  end

  assign out_tvalid    = out_tvalid_r;
  assign out_tuser     = out_tuser_r;
  assign out_tdata     = out_tdata_r;
  assign stat.out_busy = out_busy;
  assign stat.num_done = (i_r >= len_r);

  a_num_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.op == OP_NUM_WRITE) |-> (i_r < len_r))
    else $error("digit write past length");

  a_emit_digit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> (out_tuser_r == scan_r))
    else $error("emitted digit differs from scan position");

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.op == OP_CLEAR) |=> (codes_r[0] == BLANK_CODE) && !point_r[0]
                              && !cblink_r[0] && !pblink_r[0])
    else $error("clear left a digit set");

endmodule

// ----- sim/multiplexed_seven_segment_scanner_tb.sv -----
// self-checking testbench of the multiplexed seven-segment scanner
`timescale 1ns / 1ps

module multiplexed_seven_segment_scanner_tb;
  import mss_pkg::*;

  localparam logic [2:0] CMD_SPARE6 = 3'd6;
  localparam logic [2:0] CMD_SPARE7 = 3'd7;
  localparam int PHASES = 9;
  localparam int RAND_PER_PHASE = 130;
  localparam int SETTLE_CYCLES = 20;
  localparam int HOLDOFF_CYCLES = 400;

  typedef struct {
    logic [2:0]  cmd;
    logic        pos;
    logic [7:0]  code;
    logic        flag;
    logic        option;
    logic [31:0] number;
    logic [1:0]  length;
  } scan_req_t;

  typedef struct {
    digit_t     idx;
    logic [7:0] seg;
  } glyph_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;
  logic [2:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic        out_tuser;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;

  multiplexed_seven_segment_scanner DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // display model state
  code_t       disp_code [DIGITS];
  logic        disp_point [DIGITS];
  logic        blink_char [DIGITS];
  logic        blink_point [DIGITS];
  logic [16:0] blink_cnt;
  digit_t      scan_pos;
  logic [15:0] flash_half;

  logic [6:0] glyph_rom [0:12] = '{7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D,
                                   7'h07, 7'h7F, 7'h6F, 7'h00, 7'h79, 7'h73};

  scan_req_t pending_reqs[$];
  glyph_t    expected_glyphs[$];
  scan_req_t cur_req;

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int stall_left = 0;
  logic holdoff_go = 1'b0;
  int err_count = 0;
  int reqs_sent = 0;
  int glyphs_checked = 0;
  int blank_glyphs = 0;

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t ns: %s", $time, msg);
    err_count++;
  endtask

  function automatic void predict_glyph(input scan_req_t r);
    logic [16:0] twice;
    logic        visible;
    code_t       shown;
    logic        dot;
    logic [31:0] rest;
    logic [3:0]  d;
    int          n;
    glyph_t      g;
    case (r.cmd)
      CMD_TICK: begin
        twice = {flash_half, 1'b0};
        blink_cnt = blink_cnt + 17'd1;
        if (blink_cnt > twice) blink_cnt = blink_cnt - twice;
        scan_pos = (scan_pos == digit_t'(DIGITS - 1)) ? '0 : scan_pos + 1'b1;
        visible = blink_cnt < {1'b0, flash_half};
        shown = disp_code[scan_pos];
        if (blink_char[scan_pos] && !visible) shown = BLANK_CODE;
        dot = disp_point[scan_pos];
        if (blink_point[scan_pos] && !visible) dot = 1'b0;
        g.idx = scan_pos;
        g.seg = {dot, (shown <= 8'd12) ? glyph_rom[shown] : 7'h00};
        expected_glyphs.push_back(g);
      end
      CMD_SET_CHAR: disp_code[r.pos] = r.code;
      CMD_SET_POINT: disp_point[r.pos] = r.flag;
      CMD_SET_FLASH: begin
        if (r.option) blink_point[r.pos] = r.flag;
        else blink_char[r.pos] = r.flag;
      end
      CMD_SET_NUMBER: begin
        n = (r.length > DIGITS) ? DIGITS : r.length;
        rest = r.number;
        for (int i = 0; i < n; i++) begin
          d = 4'(rest % 32'd10);
          rest = rest / 32'd10;
          if (i != 0 && r.option && d == 0 && rest == 0) disp_code[i] = BLANK_CODE;
          else disp_code[i] = {4'd0, d};
        end
      end
      CMD_CLEAR: begin
        for (int i = 0; i < DIGITS; i++) begin
          disp_code[i] = BLANK_CODE;
          disp_point[i] = 1'b0;
          blink_char[i] = 1'b0;
          blink_point[i] = 1'b0;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic scan_req_t mk_req(input logic [2:0] cmd, input logic pos,
                                       input logic [7:0] code, input logic flag,
                                       input logic option, input logic [31:0] number,
                                       input logic [1:0] length);
    scan_req_t r;
    r.cmd = cmd;
    r.pos = pos;
    r.code = code;
    r.flag = flag;
    r.option = option;
    r.number = number;
    r.length = length;
    return r;
  endfunction

  function automatic scan_req_t rand_req();
    scan_req_t r;
    int sel;
    r.pos = 1'($urandom_range(1));
    r.code = ($urandom_range(9) < 8) ? 8'($urandom_range(12)) : 8'($urandom_range(255));
    r.flag = 1'($urandom_range(1));
    r.option = 1'($urandom_range(1));
    case ($urandom_range(2))
      0: r.number = $urandom_range(9);
      1: r.number = $urandom_range(120);
      default: r.number = $urandom;
    endcase
    r.length = 2'($urandom_range(3));
    sel = $urandom_range(99);
    if (sel < 50) r.cmd = CMD_TICK;
    else if (sel < 62) r.cmd = CMD_SET_CHAR;
    else if (sel < 72) r.cmd = CMD_SET_POINT;
    else if (sel < 82) r.cmd = CMD_SET_FLASH;
    else if (sel < 92) r.cmd = CMD_SET_NUMBER;
    else if (sel < 96) r.cmd = CMD_CLEAR;
    else r.cmd = $urandom_range(1) ? CMD_SPARE7 : CMD_SPARE6;
    return r;
  endfunction

  // request driver
  always @(posedge clk) begin : drive_reqs
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        predict_glyph(cur_req);
        reqs_sent++;
      end
      if (!in_tvalid || in_tready) begin
        if (pending_reqs.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
          cur_req = pending_reqs.pop_front();
          in_tvalid <= 1'b1;
          in_tuser <= cur_req.cmd;
          in_tdata <= {3'b000, cur_req.length, cur_req.number, cur_req.option,
                       cur_req.flag, cur_req.code, cur_req.pos};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver hold-off counter
  always @(posedge clk) begin
    if (holdoff_go) stall_left <= HOLDOFF_CYCLES;
    else if (stall_left != 0) stall_left <= stall_left - 1;
  end

  // result monitor
  always @(posedge clk) begin : watch_glyphs
    glyph_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_glyphs.size() == 0) begin
        report_mismatch($sformatf("unexpected result digit %0d segments %02h",
                                  out_tuser, out_tdata));
      end else begin
        e = expected_glyphs.pop_front();
        glyphs_checked++;
        if (e.seg[6:0] == 7'h00) blank_glyphs++;
        if (out_tuser !== e.idx)
          report_mismatch($sformatf("digit_index %0d, expected %0d", out_tuser, e.idx));
        if (out_tdata !== e.seg)
          report_mismatch($sformatf("segments %02h, expected %02h on digit %0d",
                                    out_tdata, e.seg, e.idx));
      end
    end
    out_tready <= (stall_left == 0) && ($urandom_range(99) >= rx_idle_pct);
  end

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_reqs.size() != 0 || in_tvalid || expected_glyphs.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    logic [15:0] half_set [PHASES];
    int made;
    scan_req_t r;
    half_set = '{16'd2, 16'd1, 16'd65535, 16'd0, 16'd5, 16'd100, 16'd3, 16'd1, 16'd7};
    flash_half = 16'd100;
    blink_cnt = '0;
    scan_pos = '0;
    for (int i = 0; i < DIGITS; i++) begin
      disp_code[i] = '0;
      disp_point[i] = 1'b0;
      blink_char[i] = 1'b0;
      blink_point[i] = 1'b0;
    end
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_drained();
      @(posedge clk);
      cfg_we <= 1'b1;
      cfg_wdata <= half_set[ph];
      @(posedge clk);
      cfg_we <= 1'b0;
      flash_half = half_set[ph];
      if (ph < 3) begin
        tx_idle_pct <= 31;
        rx_idle_pct <= 66;
      end else if (ph < 6) begin
        tx_idle_pct <= 66;
        rx_idle_pct <= 31;
      end else begin
        tx_idle_pct <= 0;
        rx_idle_pct <= 0;
      end
      @(negedge clk);
      if (ph == 0) begin
        // reset contents first, then field extremes and each command
        pending_reqs.push_back(mk_req(CMD_TICK, 1'b0, 8'h00, 1'b0, 1'b0, 32'd0, 2'd0));
        pending_reqs.push_back(mk_req(CMD_TICK, 1'b1, 8'hFF, 1'b1, 1'b1, '1, 2'd3));
        pending_reqs.push_back(mk_req(CMD_SET_CHAR, 1'b0, 8'd11, 1'b0, 1'b0, 32'd0, 2'd0));
        pending_reqs.push_back(mk_req(CMD_SET_CHAR, 1'b1, 8'd255, 1'b1, 1'b1, '1, 2'd3));
        pending_reqs.push_back(mk_req(CMD_SET_POINT, 1'b1, 8'd0, 1'b1, 1'b0, 32'd0, 2'd0));
        pending_reqs.push_back(mk_req(CMD_TICK, 1'b0, 8'd0, 1'b0, 1'b0, 32'd0, 2'd0));
        pending_reqs.push_back(mk_req(CMD_TICK, 1'b0, 8'd0, 1'b0, 1'b0, 32'd0, 2'd0));
        pending_reqs.push_back(mk_req(CMD_SET_CHAR, 1'b1, 8'd12, 1'b0, 1'b0, 32'd0, 2'd0));
        pending_reqs.push_back(mk_req(CMD_SET_FLASH, 1'b1, 8'd0, 1'b1, 1'b0, 32'd0, 2'd0));
        pending_reqs.push_back(mk_req(CMD_SET_FLASH, 1'b1, 8'd0, 1'b1, 1'b1, 32'd0, 2'd0));
        for (int i = 0; i < 4; i++)
          pending_reqs.push_back(mk_req(CMD_TICK, 1'b0, 8'd0, 1'b0, 1'b0, 32'd0, 2'd0));
        pending_reqs.push_back(mk_req(CMD_SET_NUMBER, 1'b0, 8'd0, 1'b0, 1'b1, '1, 2'd3));
        pending_reqs.push_back(mk_req(CMD_TICK, 1'b0, 8'd0, 1'b0, 1'b0, 32'd0, 2'd0));
        pending_reqs.push_back(mk_req(CMD_SET_NUMBER, 1'b0, 8'd0, 1'b0, 1'b1, 32'd0, 2'd2));
        pending_reqs.push_back(mk_req(CMD_TICK, 1'b0, 8'd0, 1'b0, 1'b0, 32'd0, 2'd0));
        pending_reqs.push_back(mk_req(CMD_SET_NUMBER, 1'b0, 8'd0, 1'b0, 1'b0, 32'd5, 2'd2));
        pending_reqs.push_back(mk_req(CMD_SET_NUMBER, 1'b0, 8'd0, 1'b0, 1'b0, 32'd77, 2'd0));
        pending_reqs.push_back(mk_req(CMD_SPARE6, 1'b1, 8'd3, 1'b1, 1'b1, 32'd9, 2'd1));
        pending_reqs.push_back(mk_req(CMD_SPARE7, 1'b0, 8'd4, 1'b0, 1'b0, 32'd8, 2'd2));
        pending_reqs.push_back(mk_req(CMD_TICK, 1'b0, 8'd0, 1'b0, 1'b0, 32'd0, 2'd0));
        pending_reqs.push_back(mk_req(CMD_CLEAR, 1'b1, 8'd1, 1'b1, 1'b1, 32'd1, 2'd1));
        pending_reqs.push_back(mk_req(CMD_TICK, 1'b0, 8'd0, 1'b0, 1'b0, 32'd0, 2'd0));
        pending_reqs.push_back(mk_req(CMD_TICK, 1'b0, 8'd0, 1'b0, 1'b0, 32'd0, 2'd0));
      end else begin
        made = 0;
        while (made < RAND_PER_PHASE) begin
          r = rand_req();
          pending_reqs.push_back(r);
          if (r.cmd != CMD_SPARE6 && r.cmd != CMD_SPARE7) made++;
        end
      end
      if (ph == 6) begin
        // long output stall while requests keep coming
        @(posedge clk);
        holdoff_go <= 1'b1;
        @(posedge clk);
        holdoff_go <= 1'b0;
      end
    end

    wait_drained();
    if (expected_glyphs.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_glyphs.size()));
    $display("%0d requests sent over %0d blink settings, %0d scan results checked",
             reqs_sent, PHASES, glyphs_checked);
    $display("%0d results had all segments dark, %0d mismatches", blank_glyphs, err_count);
    if (err_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin : watchdog
    #5000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
